// File: sv/mi3_pkg.sv
// mi3_pkg: shared widths, types and helpers of the 3x3 matrix inverse
// used by the channel interfaces, the divider step and the top level
// no dependencies
package mi3_pkg;

  // element format
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int DIM    = 3;
  localparam int NEL    = DIM * DIM;

  // internal widths, all exact
  localparam int PROD_W = 2 * DATA_W;               // 2x2 product
  localparam int COF_W  = PROD_W + 1;               // cofactor, signed
  localparam int CMAG_W = PROD_W;                   // cofactor magnitude
  localparam int PP_W   = COF_W;                    // element times cofactor half
  localparam int DET_W  = DATA_W + COF_W + 2;       // determinant, signed
  localparam int DMAG_W = DET_W - 1;                // determinant magnitude
  localparam int NUM_W  = CMAG_W + 2 * FRAC_W;      // scaled numerator
  localparam int QB     = DATA_W + 1;               // quotient bits per lane
  localparam int HI_W   = NUM_W - QB;               // numerator above quotient

  // cyclic neighbor indexes for the cofactors
  localparam int NXT1 [DIM] = '{1, 2, 0};
  localparam int NXT2 [DIM] = '{2, 0, 1};

  typedef logic signed [DATA_W-1:0] elem_t;

  // one restoring division in flight
  typedef struct packed {
    logic [DMAG_W-1:0] rem;
    logic [QB-1:0]     q;
    logic [QB-1:0]     nbits;
    logic              neg;
    logic              ovf;
  } lane_t;

  // all nine divisions of one matrix plus what rides along
  typedef struct packed {
    lane_t [NEL-1:0]   lane;
    logic [DMAG_W-1:0] dmag;
    elem_t             det;
    logic              sing;
  } dv_t;

  // signed result from magnitude and sign, saturated to the element range
  function automatic elem_t sat_mag(logic [DMAG_W-1:0] mag, logic neg, logic ovf);
    logic [DMAG_W-1:0] maxp;
    elem_t             res;
    maxp = DMAG_W'({1'b0, {(DATA_W-1){1'b1}}});
    if (neg) begin
      if (ovf || (mag > maxp + DMAG_W'(1))) res = {1'b1, {(DATA_W-1){1'b0}}};
      else res = elem_t'(-mag);
    end else begin
      if (ovf || (mag > maxp)) res = {1'b0, {(DATA_W-1){1'b1}}};
      else res = elem_t'(mag);
    end
    return res;
  endfunction

endpackage

// File: sv/mi3_if.sv
// mi3_if: valid/ready channel interfaces for matrix input and inverse output
// depends on mi3_pkg
interface mi3_in_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  elem_t m_r0c0, m_r0c1, m_r0c2;
  elem_t m_r1c0, m_r1c1, m_r1c2;
  elem_t m_r2c0, m_r2c1, m_r2c2;

  modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                  m_r2c0, m_r2c1, m_r2c2, input ready);
  modport sink   (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                  m_r2c0, m_r2c1, m_r2c2, output ready);
endinterface

interface mi3_out_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  elem_t inv_r0c0, inv_r0c1, inv_r0c2;
  elem_t inv_r1c0, inv_r1c1, inv_r1c2;
  elem_t inv_r2c0, inv_r2c1, inv_r2c2;
  elem_t determinant;
  logic  singular;

  modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                  inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, determinant, singular,
                  input ready);
  modport sink   (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                  inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, determinant, singular,
                  output ready);
endinterface

// File: sv/mi3_div_step.sv
// mi3_div_step: one restoring division step for all nine lanes
// depends on mi3_pkg
module mi3_div_step (
  input  mi3_pkg::dv_t d_i,
  output mi3_pkg::dv_t d_o
);
  import mi3_pkg::*;

  logic [DMAG_W:0] r2   [NEL];
  logic            ge   [NEL];
  logic [DMAG_W:0] diff [NEL];

  // shift in next numerator bit, subtract divisor when it fits
  always_comb begin
    d_o = d_i;
    for (int k = 0; k < NEL; k++) begin
      r2[k]   = {d_i.lane[k].rem, d_i.lane[k].nbits[QB-1]};
      ge[k]   = r2[k] >= {1'b0, d_i.dmag};
      diff[k] = r2[k] - {1'b0, d_i.dmag};
      d_o.lane[k].rem   = ge[k] ? diff[k][DMAG_W-1:0] : r2[k][DMAG_W-1:0];
      d_o.lane[k].q     = {d_i.lane[k].q[QB-2:0], ge[k]};
      d_o.lane[k].nbits = {d_i.lane[k].nbits[QB-2:0], 1'b0};
    end
  end
endmodule

// File: sv/matrix_inverse_3x3_top.sv
// matrix_inverse_3x3_top: pipelined 3x3 inverse by adjugate and exact division
// depends on mi3_pkg, mi3_if, mi3_div_step
//
// Usage: one whole matrix (nine signed Q16.16 elements) is a transfer on
// in_ch; one result (nine inverse elements, determinant, singular flag) is
// a transfer on out_ch, in input order. A transfer happens when valid and
// ready are both high at a rising clk edge.
// The pipeline has 41 register stages. Throughput: one matrix per cycle
// while out_ch keeps taking results.
// The depth is set by the divider: 33 stages, each forming one quotient
// bit of all nine quotients with a 99-bit compare and subtract; before it
// a capture stage, five stages for products, cofactors and the exact
// determinant, and a setup stage; one output stage follows it.
// Each stage has its own valid bit and moves on when the stage after it is
// empty or moving, so bubbles close up while out_ch is stalled and in_ch
// keeps taking matrices until every stage is full.
// Reset (rst_n low, synchronous) empties the pipeline; no other state.
// A zero determinant gives singular high and all other fields zero.
module matrix_inverse_3x3_top (
  input  logic           clk,
  input  logic           rst_n,
  mi3_in_if.sink         in_ch,
  mi3_out_if.source      out_ch
);
  import mi3_pkg::*;

  localparam int S_SET = 7;
  localparam int NS    = S_SET + QB + 1;

  logic [NS:1]   v_r;
  logic [NS+1:1] adv;

  elem_t                    m1_r   [DIM][DIM];
  logic signed [PROD_W-1:0] pa2_r  [DIM][DIM];
  logic signed [PROD_W-1:0] pb2_r  [DIM][DIM];
  elem_t                    row2_r [DIM];
  logic signed [COF_W-1:0]  adj3_r [DIM][DIM];
  elem_t                    row3_r [DIM];
  logic signed [COF_W-1:0]  adj4_r [DIM][DIM];
  logic signed [PP_W-1:0]   pl4_r  [DIM];
  logic signed [PP_W-1:0]   ph4_r  [DIM];
  logic signed [COF_W-1:0]  adj5_r [DIM][DIM];
  logic signed [DET_W-1:0]  t5_r   [DIM];
  logic signed [COF_W-1:0]  adj6_r [DIM][DIM];
  logic signed [DET_W-1:0]  d6_r;
  dv_t                      dv_r   [QB+1];
  dv_t                      dv_nxt [QB];
  elem_t                    inv_r  [NEL];
  elem_t                    det_r;
  logic                     sing_r;

  // stage advance chain from the output back to the input
  always_comb begin
    adv[NS+1] = out_ch.ready;
    for (int s = NS; s >= 1; s--) adv[s] = !v_r[s] || adv[s+1];
  end

  assign in_ch.ready = adv[1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[1]) v_r[1] <= in_ch.valid;
      for (int s = 2; s <= NS; s++) begin
        if (adv[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // stage 1: matrix capture
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      m1_r[0][0] <= in_ch.m_r0c0; m1_r[0][1] <= in_ch.m_r0c1; m1_r[0][2] <= in_ch.m_r0c2;
      m1_r[1][0] <= in_ch.m_r1c0; m1_r[1][1] <= in_ch.m_r1c1; m1_r[1][2] <= in_ch.m_r1c2;
      m1_r[2][0] <= in_ch.m_r2c0; m1_r[2][1] <= in_ch.m_r2c1; m1_r[2][2] <= in_ch.m_r2c2;
    end
  end

  // stage 2: the two products of each cyclic cofactor
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          pa2_r[i][j] <= PROD_W'(m1_r[NXT1[j]][NXT1[i]]) * PROD_W'(m1_r[NXT2[j]][NXT2[i]]);
          pb2_r[i][j] <= PROD_W'(m1_r[NXT2[j]][NXT1[i]]) * PROD_W'(m1_r[NXT1[j]][NXT2[i]]);
        end
        row2_r[i] <= m1_r[0][i];
      end
    end
  end

  // stage 3: adjugate elements
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          adj3_r[i][j] <= COF_W'(pa2_r[i][j]) - COF_W'(pb2_r[i][j]);
        end
        row3_r[i] <= row2_r[i];
      end
    end
  end

  // stage 4: first row times first adjugate column, split in halves
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      adj4_r <= adj3_r;
      for (int k = 0; k < DIM; k++) begin
        pl4_r[k] <= PP_W'(row3_r[k]) * PP_W'($signed({1'b0, adj3_r[k][0][DATA_W-1:0]}));
        ph4_r[k] <= PP_W'(row3_r[k]) * PP_W'($signed(adj3_r[k][0][COF_W-1:DATA_W]));
      end
    end
  end

  // stage 5: join halves into full terms
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      adj5_r <= adj4_r;
      for (int k = 0; k < DIM; k++) begin
        t5_r[k] <= (DET_W'(ph4_r[k]) <<< DATA_W) + DET_W'(pl4_r[k]);
      end
    end
  end

  // stage 6: exact determinant
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      adj6_r <= adj5_r;
      d6_r   <= t5_r[0] + t5_r[1] + t5_r[2];
    end
  end

  // stage 7 setup: magnitudes, signs, overflow screen, first remainder
  logic              dneg;
  logic [DMAG_W-1:0] dmag;
  logic [DMAG_W-1:0] dround;
  logic              cneg [NEL];
  logic [CMAG_W-1:0] cmag [NEL];
  logic [NUM_W-1:0]  num  [NEL];
  logic [DMAG_W-1:0] hi   [NEL];
  dv_t               set_nxt;

  always_comb begin
    dneg   = d6_r[DET_W-1];
    dmag   = dneg ? DMAG_W'(-d6_r) : DMAG_W'(d6_r);
    dround = (dmag >> (2 * FRAC_W)) + DMAG_W'(dmag[2*FRAC_W-1]);
    set_nxt.dmag = dmag;
    set_nxt.sing = (d6_r == '0);
    set_nxt.det  = sat_mag(dround, dneg, 1'b0);
    for (int k = 0; k < NEL; k++) begin
      cneg[k] = adj6_r[k / DIM][k % DIM][COF_W-1];
      cmag[k] = cneg[k] ? CMAG_W'(-adj6_r[k / DIM][k % DIM])
                        : CMAG_W'(adj6_r[k / DIM][k % DIM]);
      num[k]  = {cmag[k], {(2*FRAC_W){1'b0}}};
      hi[k]   = DMAG_W'(num[k][NUM_W-1:QB]);
      set_nxt.lane[k].ovf   = hi[k] >= dmag;
      set_nxt.lane[k].rem   = set_nxt.lane[k].ovf ? '0 : hi[k];
      set_nxt.lane[k].q     = '0;
      set_nxt.lane[k].nbits = num[k][QB-1:0];
      set_nxt.lane[k].neg   = cneg[k] ^ dneg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[S_SET]) dv_r[0] <= set_nxt;
  end

  // divider: one quotient bit per stage
  for (genvar g = 0; g < QB; g++) begin : g_div
    mi3_div_step u_step (.d_i(dv_r[g]), .d_o(dv_nxt[g]));
    always_ff @(posedge clk) begin
      if (adv[S_SET+1+g]) dv_r[g+1] <= dv_nxt[g];
    end
  end

  // output stage: round to nearest, apply sign, saturate
  logic              rnd [NEL];
  logic [DMAG_W-1:0] mag [NEL];

  always_comb begin
    for (int k = 0; k < NEL; k++) begin
      rnd[k] = {dv_r[QB].lane[k].rem, 1'b0} >= {1'b0, dv_r[QB].dmag};
      mag[k] = DMAG_W'(dv_r[QB].lane[k].q) + DMAG_W'(rnd[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS]) begin
      for (int k = 0; k < NEL; k++) begin
        inv_r[k] <= dv_r[QB].sing ? '0
                    : sat_mag(mag[k], dv_r[QB].lane[k].neg, dv_r[QB].lane[k].ovf);
      end
      det_r  <= dv_r[QB].sing ? '0 : dv_r[QB].det;
      sing_r <= dv_r[QB].sing;
    end
  end

  assign out_ch.valid       = v_r[NS];
  assign out_ch.inv_r0c0    = inv_r[0];
  assign out_ch.inv_r0c1    = inv_r[1];
  assign out_ch.inv_r0c2    = inv_r[2];
  assign out_ch.inv_r1c0    = inv_r[3];
  assign out_ch.inv_r1c1    = inv_r[4];
  assign out_ch.inv_r1c2    = inv_r[5];
  assign out_ch.inv_r2c0    = inv_r[6];
  assign out_ch.inv_r2c1    = inv_r[7];
  assign out_ch.inv_r2c2    = inv_r[8];
  assign out_ch.determinant = det_r;
  assign out_ch.singular    = sing_r;

`ifndef SYNTH
  // input held off only when every stage holds a matrix
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled with an empty stage");

  // singular result carries a zero determinant and zero diagonal inverse elements
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.singular |->
      out_ch.determinant == '0 && out_ch.inv_r0c0 == '0 && out_ch.inv_r1c1 == '0 &&
      out_ch.inv_r2c2 == '0)
    else $error("singular result with nonzero fields");

  // nonzero determinant is never flagged singular
  a_det_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.determinant != '0 |-> !out_ch.singular)
    else $error("nonzero determinant flagged singular");

  // a held result keeps its valid, determinant and singular flag until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS] && !out_ch.ready |=> v_r[NS] && $stable(det_r) && $stable(sing_r))
    else $error("stalled result lost or changed");
`endif

endmodule

// File: tb/matrix_inverse_3x3_top_tb.sv
// matrix_inverse_3x3_top_tb: checks the 3x3 inverse against an exact-arithmetic
// predictor, with random idling on both channels
// depends on mi3_pkg, mi3_if, matrix_inverse_3x3_top
module matrix_inverse_3x3_top_tb;
  import mi3_pkg::*;

  localparam int N_RANDOM    = 430;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct packed {
    elem_t [NEL-1:0] m;
  } matrix_t;

  typedef struct packed {
    elem_t [NEL-1:0] inv;
    elem_t           det;
    logic            sing;
  } inverse_t;

  logic clk;
  logic rst_n;

  mi3_in_if  in_ch ();
  mi3_out_if out_ch ();

  matrix_inverse_3x3_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  matrix_t  pending_mats[$];
  inverse_t expected_invs[$];
  int       cycle_count;
  int       fail_count = 0;
  logic     stim_done;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exact signed quotient, rounded to nearest with ties away from zero
  function automatic logic signed [255:0] round_div(logic signed [255:0] num,
                                                     logic signed [255:0] den);
    logic signed [255:0] an, ad, q, r;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q  = an / ad;
    r  = an - q * ad;
    if (2 * r >= ad) q = q + 1;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic elem_t clamp_elem(logic signed [255:0] v);
    if (v > 256'sd2147483647) return 32'h7fffffff;
    if (v < -256'sd2147483648) return 32'h80000000;
    return elem_t'(v);
  endfunction

  // predicted inverse, determinant and singular flag of one matrix
  function automatic inverse_t invert_matrix(matrix_t mt);
    logic signed [255:0] a[3][3];
    logic signed [255:0] det, cof;
    inverse_t res;
    int i1, i2, j1, j2;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        a[r][c] = 256'(signed'(mt.m[r*3+c]));
    det = a[0][0]*a[1][1]*a[2][2] + a[0][1]*a[1][2]*a[2][0] + a[0][2]*a[1][0]*a[2][1]
        - a[0][2]*a[1][1]*a[2][0] - a[0][1]*a[1][0]*a[2][2] - a[0][0]*a[1][2]*a[2][1];
    res = '0;
    if (det == 0) begin
      res.sing = 1'b1;
      return res;
    end
    // cofactors of the transpose: t[i][j] = a[j][i]
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        i1 = (i + 1) % 3; i2 = (i + 2) % 3;
        j1 = (j + 1) % 3; j2 = (j + 2) % 3;
        cof = a[j1][i1] * a[j2][i2] - a[j2][i1] * a[j1][i2];
        res.inv[i*3+j] = clamp_elem(round_div(cof <<< (2*FRAC_W), det));
      end
    res.det = clamp_elem(round_div(det, 256'sd1 <<< (2*FRAC_W)));
    return res;
  endfunction

  function automatic elem_t rand_elem(int mode);
    case (mode)
      0: return elem_t'($urandom);
      1: return elem_t'($signed($urandom_range(0, 8 << FRAC_W)) - (4 << FRAC_W));
      2: return elem_t'($signed($urandom_range(0, 64)) - 32);
      default: return elem_t'(($urandom_range(0, 6) - 3) <<< FRAC_W);
    endcase
  endfunction

  function automatic matrix_t diag_matrix(elem_t d);
    matrix_t mt;
    mt = '0;
    mt.m[0] = d; mt.m[4] = d; mt.m[8] = d;
    return mt;
  endfunction

  // stimulus
  initial begin
    matrix_t mt;
    int mode;
    stim_done = 1'b0;
    pending_mats.push_back(diag_matrix(32'sd65536));            // identity
    pending_mats.push_back(diag_matrix(32'sd131072));
    pending_mats.push_back(diag_matrix(-32'sd65536));
    pending_mats.push_back(diag_matrix(32'h7fffffff));          // huge determinant
    pending_mats.push_back(diag_matrix(32'h80000000));
    pending_mats.push_back(diag_matrix(32'sd1));                // tiny determinant
    pending_mats.push_back(diag_matrix(32'sd256));
    pending_mats.push_back('0);                                 // zero matrix
    mt = '0;
    for (int k = 0; k < NEL; k++) mt.m[k] = 32'h7fffffff;       // rank one
    pending_mats.push_back(mt);
    for (int k = 0; k < NEL; k++) mt.m[k] = 32'h80000000;
    pending_mats.push_back(mt);
    for (int k = 0; k < NEL; k++) mt.m[k] = (k % 2) ? 32'h80000000 : 32'h7fffffff;
    pending_mats.push_back(mt);
    for (int k = 0; k < NEL; k++) mt.m[k] = elem_t'((k + 1) <<< FRAC_W); // singular 1..9
    pending_mats.push_back(mt);
    mt.m[8] = elem_t'(10 <<< FRAC_W);
    pending_mats.push_back(mt);
    for (int k = 0; k < NEL; k++) mt.m[k] = 32'hffffffff;
    mt.m[0] = 32'h0; mt.m[4] = 32'h0; mt.m[8] = 32'h0;
    pending_mats.push_back(mt);
    for (int k = 0; k < NEL; k++) mt.m[k] = 32'h55555555 ^ (k[0] ? 32'hffffffff : 32'h0);
    pending_mats.push_back(mt);
    // random, mostly well-conditioned small values with some full range
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 3);
      for (int k = 0; k < NEL; k++) mt.m[k] = rand_elem(mode);
      if ($urandom_range(0, 15) == 0) begin
        // duplicate a row to force a singular matrix
        for (int c = 0; c < 3; c++) mt.m[3+c] = mt.m[c];
      end
      pending_mats.push_back(mt);
    end
    stim_done = 1'b1;
  end

  // reset sequence
  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // idling: random breaks, none in a stretch in the middle of the run
  function automatic logic take_break();
    if (cycle_count > 150 && cycle_count < 350) return 1'b0;
    return $urandom_range(0, 99) < 6;
  endfunction

  // input driver
  always @(posedge clk) begin
    matrix_t mt;
    logic fire;
    fire = rst_n && in_ch.valid && in_ch.ready;
    if (fire) begin
      mt = pending_mats.pop_front();
      expected_invs.push_back(invert_matrix(mt));
    end
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      {in_ch.m_r0c0, in_ch.m_r0c1, in_ch.m_r0c2, in_ch.m_r1c0, in_ch.m_r1c1,
       in_ch.m_r1c2, in_ch.m_r2c0, in_ch.m_r2c1, in_ch.m_r2c2} <= '0;
    end else if ((!in_ch.valid || fire) && pending_mats.size() > 0 && !take_break()) begin
      mt = pending_mats[0];
      in_ch.valid  <= 1'b1;
      in_ch.m_r0c0 <= mt.m[0]; in_ch.m_r0c1 <= mt.m[1]; in_ch.m_r0c2 <= mt.m[2];
      in_ch.m_r1c0 <= mt.m[3]; in_ch.m_r1c1 <= mt.m[4]; in_ch.m_r1c2 <= mt.m[5];
      in_ch.m_r2c0 <= mt.m[6]; in_ch.m_r2c1 <= mt.m[7]; in_ch.m_r2c2 <= mt.m[8];
    end else if (fire) begin
      in_ch.valid <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    inverse_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_invs.size() == 0) begin
        $error("result transfer with no expectation waiting");
        fail_count++;
      end else begin
        e = expected_invs.pop_front();
        check_field("inv_r0c0", e.inv[0], out_ch.inv_r0c0);
        check_field("inv_r0c1", e.inv[1], out_ch.inv_r0c1);
        check_field("inv_r0c2", e.inv[2], out_ch.inv_r0c2);
        check_field("inv_r1c0", e.inv[3], out_ch.inv_r1c0);
        check_field("inv_r1c1", e.inv[4], out_ch.inv_r1c1);
        check_field("inv_r1c2", e.inv[5], out_ch.inv_r1c2);
        check_field("inv_r2c0", e.inv[6], out_ch.inv_r2c0);
        check_field("inv_r2c1", e.inv[7], out_ch.inv_r2c1);
        check_field("inv_r2c2", e.inv[8], out_ch.inv_r2c2);
        check_field("determinant", e.det, out_ch.determinant);
        check_field("singular", 32'(e.sing), 32'(out_ch.singular));
      end
    end
    out_ch.ready <= rst_n && !take_break();
  end

  // cycle limit and end of run
  initial begin
    cycle_count = 0;
    fork
      begin
        wait (rst_n === 1'b1);
        wait (stim_done && pending_mats.size() == 0 && !in_ch.valid);
        wait (expected_invs.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && expected_invs.size() == 0) begin
          $display("matrix_inverse_3x3_top_tb: PASS");
        end else begin
          $display("matrix_inverse_3x3_top_tb: FAIL");
        end
        $finish;
      end
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(posedge clk);
          cycle_count++;
        end
        $error("timeout after %0d cycles", cycle_count);
        $display("matrix_inverse_3x3_top_tb: FAIL");
        $finish;
      end
    join
  end

endmodule
